// File: rtl/core/rrt_pkg.sv
`default_nettype none
package rrt_pkg;

   localparam int unsigned QBITS = 29;
   localparam int unsigned DIV_LAT = 31;
   localparam logic signed [29:0] ONE_Q28 = 30'sd268435456;

   typedef struct packed {
      logic [63:0]        first_orient;
      logic signed [31:0] first_pos_x;
      logic signed [31:0] first_pos_y;
      logic signed [31:0] first_pos_z;
      logic [63:0]        second_orient;
      logic signed [31:0] second_pos_x;
      logic signed [31:0] second_pos_y;
      logic signed [31:0] second_pos_z;
   } rrt_req_type;

   typedef struct packed {
      logic signed [15:0] rel_rot_00;
      logic signed [15:0] rel_rot_01;
      logic signed [15:0] rel_rot_02;
      logic signed [15:0] rel_rot_10;
      logic signed [15:0] rel_rot_11;
      logic signed [15:0] rel_rot_12;
      logic signed [15:0] rel_rot_20;
      logic signed [15:0] rel_rot_21;
      logic signed [15:0] rel_rot_22;
      logic signed [31:0] rel_shift_x;
      logic signed [31:0] rel_shift_y;
      logic signed [31:0] rel_shift_z;
   } rrt_rsp_type;

   typedef struct packed {
      logic             valid;
      logic             zero1;
      logic             zero2;
      logic [2:0][32:0] diff;
   } rrt_side_type;

endpackage
`default_nettype wire

// File: rtl/core/rrt_quat_front.sv
`default_nettype none
module rrt_quat_front
   import rrt_pkg::*;
(
   input  wire logic             clock,
   input  wire logic [63:0]      orient,
   output logic      [8:0][33:0] num,
   output logic      [32:0]      norm,
   output logic                  zero
);

   logic signed [15:0] w, x, y, z;
   logic signed [31:0] ww_ff, xx_ff, yy_ff, zz_ff, xy_ff, wz_ff, xz_ff, wy_ff, yz_ff, wx_ff;
   logic signed [33:0] ww, xx, yy, zz, xy, wz, xz, wy, yz, wx, nsum;
   logic [8:0][33:0]   num_in;
   logic [8:0][33:0]   num_ff;
   logic [32:0]        norm_ff;
   logic               zero_ff;

   assign w = $signed(orient[63:48]);
   assign x = $signed(orient[47:32]);
   assign y = $signed(orient[31:16]);
   assign z = $signed(orient[15:0]);

   always_ff @(posedge clock) begin
      ww_ff <= w * w;
      xx_ff <= x * x;
      yy_ff <= y * y;
      zz_ff <= z * z;
      xy_ff <= x * y;
      wz_ff <= w * z;
      xz_ff <= x * z;
      wy_ff <= w * y;
      yz_ff <= y * z;
      wx_ff <= w * x;
   end

   always_comb begin
      ww = 34'(ww_ff);
      xx = 34'(xx_ff);
      yy = 34'(yy_ff);
      zz = 34'(zz_ff);
      xy = 34'(xy_ff);
      wz = 34'(wz_ff);
      xz = 34'(xz_ff);
      wy = 34'(wy_ff);
      yz = 34'(yz_ff);
      wx = 34'(wx_ff);
      nsum = ww + xx + yy + zz;
      num_in[0] = ww + xx - yy - zz;
      num_in[1] = (xy - wz) <<< 1;
      num_in[2] = (xz + wy) <<< 1;
      num_in[3] = (xy + wz) <<< 1;
      num_in[4] = ww - xx + yy - zz;
      num_in[5] = (yz - wx) <<< 1;
      num_in[6] = (xz - wy) <<< 1;
      num_in[7] = (yz + wx) <<< 1;
      num_in[8] = ww - xx - yy + zz;
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      norm_ff <= nsum[32:0];
      zero_ff <= (nsum == 34'sd0);
   end

   assign num  = num_ff;
   assign norm = norm_ff;
   assign zero = zero_ff;

endmodule
`default_nettype wire

// File: rtl/core/rrt_divider.sv
`default_nettype none
module rrt_divider
   import rrt_pkg::*;
(
   input  wire logic               clock,
   input  wire logic signed [33:0] num,
   input  wire logic        [32:0] norm,
   output logic signed      [29:0] quot
);

   logic        neg_in;
   logic [33:0] mag_full;
   logic [60:0] dvd;

   logic [32:0]       rem_ff  [0:QBITS];
   logic [QBITS-1:0]  low_ff  [0:QBITS];
   logic [QBITS-1:0]  q_ff    [0:QBITS];
   logic [32:0]       n_ff    [0:QBITS];
   logic              neg_ff  [0:QBITS];
   logic signed [29:0] quot_ff;

   always_comb begin
      neg_in   = num[33];
      mag_full = neg_in ? 34'(-num) : 34'(num);
      dvd      = {mag_full[32:0], 28'd0} + 61'(norm >> 1);
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= {1'b0, dvd[60:29]};
      low_ff[0] <= dvd[28:0];
      q_ff[0]   <= '0;
      n_ff[0]   <= norm;
      neg_ff[0] <= neg_in;
   end

   for (genvar s = 0; s < QBITS; s++) begin : g_step
      logic [33:0] trial;
      logic [33:0] diff;
      logic        ge;
      always_comb begin
         trial = {rem_ff[s], low_ff[s][QBITS-1]};
         diff  = trial - {1'b0, n_ff[s]};
         ge    = trial >= {1'b0, n_ff[s]};
      end
      always_ff @(posedge clock) begin
         rem_ff[s+1] <= ge ? diff[32:0] : trial[32:0];
         low_ff[s+1] <= {low_ff[s][QBITS-2:0], 1'b0};
         q_ff[s+1]   <= {q_ff[s][QBITS-2:0], ge};
         n_ff[s+1]   <= n_ff[s];
         neg_ff[s+1] <= neg_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= neg_ff[QBITS] ? -$signed({1'b0, q_ff[QBITS]}) : $signed({1'b0, q_ff[QBITS]});
   end

   assign quot = quot_ff;

endmodule
`default_nettype wire

// File: rtl/core/rrt_combine.sv
`default_nettype none
module rrt_combine
   import rrt_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             valid,
   input  wire logic             zero1,
   input  wire logic             zero2,
   input  wire logic [2:0][32:0] diff,
   input  wire logic [8:0][29:0] r1,
   input  wire logic [8:0][29:0] r2,
   output logic                  strobe,
   output rrt_rsp_type           rsp
);

   logic signed [29:0] a1 [3][3];
   logic signed [29:0] a2 [3][3];
   logic signed [59:0] pr_ff [3][3][3];
   logic signed [62:0] pt_ff [3][3];
   logic signed [61:0] sr_ff [3][3];
   logic signed [64:0] st_ff [3];
   logic               v1_ff, v2_ff, strobe_ff;
   logic [61:0]        magr [3][3];
   logic [19:0]        rr   [3][3];
   logic signed [15:0] rot  [3][3];
   logic [64:0]        magt [3];
   logic [36:0]        rt   [3];
   logic signed [31:0] sh   [3];
   rrt_rsp_type        rsp_in, rsp_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         for (int i = 0; i < 3; i++) begin
            a1[k][i] = zero1 ? ((k == i) ? ONE_Q28 : 30'sd0) : $signed(r1[k*3+i]);
            a2[k][i] = zero2 ? ((k == i) ? ONE_Q28 : 30'sd0) : $signed(r2[k*3+i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
               pr_ff[i][j][k] <= a1[k][i] * a2[k][j];
            end
            pt_ff[i][k] <= a1[k][i] * $signed(diff[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            sr_ff[i][j] <= 62'(pr_ff[i][j][0]) + 62'(pr_ff[i][j][1]) + 62'(pr_ff[i][j][2]);
         end
         st_ff[i] <= 65'(pt_ff[i][0]) + 65'(pt_ff[i][1]) + 65'(pt_ff[i][2]);
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            magr[i][j] = sr_ff[i][j][61] ? 62'(-sr_ff[i][j]) : 62'(sr_ff[i][j]);
            rr[i][j]   = 20'((magr[i][j] + (62'd1 << 41)) >> 42);
            if (rr[i][j] > 20'd16384) begin
               rr[i][j] = 20'd16384;
            end
            rot[i][j] = sr_ff[i][j][61] ? -$signed(rr[i][j][15:0]) : $signed(rr[i][j][15:0]);
         end
         magt[i] = st_ff[i][64] ? 65'(-st_ff[i]) : 65'(st_ff[i]);
         rt[i]   = 37'((magt[i] + (65'd1 << 27)) >> 28);
         if (st_ff[i][64]) begin
            sh[i] = (rt[i] > 37'h0080000000) ? 32'sh80000000 : -$signed(rt[i][31:0]);
         end else begin
            sh[i] = (rt[i] > 37'h007fffffff) ? 32'sh7fffffff : $signed(rt[i][31:0]);
         end
      end
      rsp_in.rel_rot_00  = rot[0][0];
      rsp_in.rel_rot_01  = rot[0][1];
      rsp_in.rel_rot_02  = rot[0][2];
      rsp_in.rel_rot_10  = rot[1][0];
      rsp_in.rel_rot_11  = rot[1][1];
      rsp_in.rel_rot_12  = rot[1][2];
      rsp_in.rel_rot_20  = rot[2][0];
      rsp_in.rel_rot_21  = rot[2][1];
      rsp_in.rel_rot_22  = rot[2][2];
      rsp_in.rel_shift_x = sh[0];
      rsp_in.rel_shift_y = sh[1];
      rsp_in.rel_shift_z = sh[2];
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         v1_ff     <= valid;
         v2_ff     <= v1_ff;
         strobe_ff <= v2_ff;
      end
   end

   assign strobe = strobe_ff;
   assign rsp    = rsp_ff;

endmodule
`default_nettype wire

// File: rtl/core/relative_rigid_transform_unit.sv
// channel   ports                          word
// request   start, busy, req_data          two poses, quaternion and position each
// response  rsp_strobe, rsp_data           relative rotation and translation
//
// one word enters per clock; the result passes the front, divider and combine stages, then strobes
// the 29-step pipelined dividers produce one quotient bit per stage
// synchronous reset clears the valid bits and the side pipeline; busy is always low
// the receiver cannot stall, so the pipeline never holds
`default_nettype none
module relative_rigid_transform_unit
   import rrt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire rrt_req_type req_data,
   output logic             rsp_strobe,
   output rrt_rsp_type      rsp_data
);

   rrt_req_type      req_ff;
   logic             v0_ff, v1_ff, v2_ff;
   logic [2:0][32:0] d1_ff, d2_ff;
   logic [8:0][33:0] num1, num2;
   logic [32:0]      norm1, norm2;
   logic             zero1, zero2;
   logic [8:0][29:0] r1, r2;
   rrt_side_type     side_ff [0:DIV_LAT-1];

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      req_ff <= req_data;
      d1_ff[0] <= 33'(req_ff.second_pos_x) - 33'(req_ff.first_pos_x);
      d1_ff[1] <= 33'(req_ff.second_pos_y) - 33'(req_ff.first_pos_y);
      d1_ff[2] <= 33'(req_ff.second_pos_z) - 33'(req_ff.first_pos_z);
      d2_ff <= d1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v0_ff <= start & ~busy;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
   end

   rrt_quat_front u_front1 (
      .clock  (clock),
      .orient (req_ff.first_orient),
      .num    (num1),
      .norm   (norm1),
      .zero   (zero1)
   );

   rrt_quat_front u_front2 (
      .clock  (clock),
      .orient (req_ff.second_orient),
      .num    (num2),
      .norm   (norm2),
      .zero   (zero2)
   );

   for (genvar e = 0; e < 9; e++) begin : g_div
      rrt_divider u_div1 (
         .clock (clock),
         .num   ($signed(num1[e])),
         .norm  (norm1),
         .quot  (r1[e])
      );
      rrt_divider u_div2 (
         .clock (clock),
         .num   ($signed(num2[e])),
         .norm  (norm2),
         .quot  (r2[e])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < DIV_LAT; s++) begin
            side_ff[s] <= '0;
         end
      end else begin
         side_ff[0] <= '{valid: v2_ff, zero1: zero1, zero2: zero2, diff: d2_ff};
         for (int s = 1; s < DIV_LAT; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   rrt_combine u_combine (
      .clock  (clock),
      .reset  (reset),
      .valid  (side_ff[DIV_LAT-1].valid),
      .zero1  (side_ff[DIV_LAT-1].zero1),
      .zero2  (side_ff[DIV_LAT-1].zero2),
      .diff   (side_ff[DIV_LAT-1].diff),
      .r1     (r1),
      .r2     (r2),
      .strobe (rsp_strobe),
      .rsp    (rsp_data)
   );

endmodule
`default_nettype wire
